// ----- rtl/core/dltq_pkg.sv -----
package dltq_pkg;

  typedef enum logic [2:0] {
    ACT_ADD_BACK   = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_TAKE_FRONT = 3'd2,
    ACT_ERASE      = 3'd3,
    ACT_PEEK_FRONT = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] task_slot;
  } req_t;

  typedef struct packed {
    logic [5:0] out_task;
    logic       out_valid;
    logic       queue_empty;
    logic       op_error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage

// ----- rtl/core/dltq_ram.sv -----
module dltq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/doubly_linked_task_queue_core.sv -----
// Steps after the accepting edge of a request word: link read, link/neighbor write, then
// the result with the second neighbor write, held until the result word is accepted.
// Requests: one request is held at a time and a stalled result holds off the next request;
// no new request is taken before the result word of the held one has been accepted.
// Reset: head and tail null; the queued flags are cleared by a pass over all TASK_SLOTS slots
// with input held off; link memories are not cleared, a link is read only after a write.
module doubly_linked_task_queue_core #(
  parameter int TASK_SLOTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dltq_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dltq_pkg::rsp_t  out_data_o
);
  import dltq_pkg::*;

  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TASK_SLOTS - 1);

  state_e state_q, state_d;
  req_t   req_q;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] clr_q, clr_d;
  rsp_t   rsp_q, rsp_d;

  // memory ports
  logic          nx_we, pv_we, qf_we;
  logic [AW-1:0] nx_wa, pv_wa, qf_wa, rd_a;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic          qf_wd, qf_rd;

  // second write held for the output cycle
  logic          w2n_q, w2n_d, w2p_q, w2p_d;
  logic [AW-1:0] w2a_q, w2a_d;
  logic [LW-1:0] w2v_q, w2v_d;

  dltq_ram #(.Width(LW), .Depth(TASK_SLOTS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(rd_a), .rdata_o(nx_rd));
  dltq_ram #(.Width(LW), .Depth(TASK_SLOTS)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .raddr_i(rd_a), .rdata_o(pv_rd));
  dltq_ram #(.Width(1), .Depth(TASK_SLOTS)) u_queued (
    .clk_i, .we_i(qf_we), .waddr_i(qf_wa), .wdata_i(qf_wd),
    .raddr_i(rd_a), .rdata_o(qf_rd));

  // decode the held request
  logic          in_pool, is_q;
  logic [AW-1:0] slot, hslot, tslot;
  assign in_pool = (32'(req_q.task_slot) < TASK_SLOTS);
  assign slot    = AW'(req_q.task_slot);
  assign hslot   = head_q[AW-1:0];
  assign tslot   = tail_q[AW-1:0];
  assign is_q    = in_pool && qf_rd;

  // address the read: unlink target is head for pop, slot for erase; other actions read slot
  assign rd_a = (req_q.action == ACT_TAKE_FRONT) ? hslot : slot;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == LAST_SLOT) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d = head_q; tail_d = tail_q; rsp_d = rsp_q; clr_d = clr_q;
    nx_we = 1'b0; pv_we = 1'b0; qf_we = 1'b0;
    nx_wa = slot; pv_wa = slot; qf_wa = slot;
    nx_wd = NIL; pv_wd = NIL; qf_wd = 1'b0;
    w2n_d = 1'b0; w2p_d = 1'b0; w2a_d = w2a_q; w2v_d = w2v_q;
    case (state_q)
      ST_CLEAR: begin
        qf_we = 1'b1; qf_wa = clr_q; qf_wd = 1'b0;
        clr_d = clr_q + AW'(1);
      end
      ST_OUT: begin
        nx_we = w2n_q; pv_we = w2p_q;
        nx_wa = w2a_q; pv_wa = w2a_q; nx_wd = w2v_q; pv_wd = w2v_q;
      end
      ST_WRITE: begin
        rsp_d = '0;
        case (req_q.action)
          ACT_ADD_BACK, ACT_PUSH_FRONT: begin
            if (!in_pool || qf_rd) begin
              rsp_d.op_error = 1'b1;
            end else begin
              qf_we = 1'b1; qf_wa = slot; qf_wd = 1'b1;
              nx_we = 1'b1; pv_we = 1'b1;
              if (req_q.action == ACT_ADD_BACK) begin
                nx_wd = NIL; pv_wd = tail_q;
                tail_d = LW'(slot);
                if (head_q == NIL) head_d = LW'(slot);
                else begin
                  w2n_d = 1'b1; w2a_d = tslot; w2v_d = LW'(slot);
                end
              end else begin
                pv_wd = NIL; nx_wd = head_q;
                head_d = LW'(slot);
                if (head_q == NIL) tail_d = LW'(slot);
                else begin
                  w2p_d = 1'b1; w2a_d = hslot; w2v_d = LW'(slot);
                end
              end
            end
          end
          ACT_TAKE_FRONT, ACT_ERASE, ACT_PEEK_FRONT: begin
            if (req_q.action == ACT_ERASE && !is_q) begin
              rsp_d.op_error = 1'b1;
            end else if (req_q.action != ACT_ERASE && head_q == NIL) begin
              rsp_d.out_valid = 1'b0;
            end else if (req_q.action == ACT_PEEK_FRONT) begin
              rsp_d.out_valid = 1'b1;
              rsp_d.out_task  = 6'(hslot);
            end else begin
              if (req_q.action == ACT_TAKE_FRONT) begin
                rsp_d.out_valid = 1'b1;
                rsp_d.out_task  = 6'(hslot);
              end
              qf_we = 1'b1; qf_wa = rd_a; qf_wd = 1'b0;
              // splice neighbors: prev.next = n now, next.prev = p later
              if (pv_rd != NIL) begin
                nx_we = 1'b1; nx_wa = pv_rd[AW-1:0]; nx_wd = nx_rd;
              end else head_d = nx_rd;
              if (nx_rd != NIL) begin
                w2p_d = 1'b1; w2a_d = nx_rd[AW-1:0]; w2v_d = pv_rd;
              end else tail_d = pv_rd;
            end
          end
          default: ;
        endcase
        rsp_d.queue_empty = (head_d == NIL);
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = rsp_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      head_q  <= NIL;
      tail_q  <= NIL;
      clr_q   <= '0;
      w2n_q   <= 1'b0;
      w2p_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      clr_q   <= clr_d;
      w2n_q   <= w2n_d;
      w2p_q   <= w2p_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    rsp_q <= rsp_d;
    w2a_q <= w2a_d;
    w2v_q <= w2v_d;
  end

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NIL) == (tail_q == NIL)) else $error("head/tail disagree");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input open while result waits");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(w2n_q && w2p_q)) else $error("two pending neighbor writes");
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rsp_q.out_valid && rsp_q.op_error)) else $error("bad result");

endmodule

// ----- test/doubly_linked_task_queue_core_test.sv -----
`timescale 1ns / 1ps

module doubly_linked_task_queue_core_test;
  import dltq_pkg::*;

  localparam int SLOTS = 64;
  localparam int NIL = SLOTS;
  localparam int IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  // shadow run queue
  int head_q, tail_q;
  int next_q[SLOTS];
  int prev_q[SLOTS];
  bit queued_q[SLOTS];
  int queued_count;

  rsp_t expected_words[$];
  int fail_count = 0;
  int word_count = 0;
  int idle_cycles = 0;

  doubly_linked_task_queue_core #(.TASK_SLOTS(SLOTS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void queued_flag_clear(int t);
    queued_q[t] = 1'b0;
  endfunction

  function automatic void clear_queue();
    head_q = NIL;
    tail_q = NIL;
    queued_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      next_q[i] = NIL;
      prev_q[i] = NIL;
      queued_flag_clear(i);
    end
  endfunction

  function automatic void unlink_task(int t);
    int p, n;
    p = prev_q[t];
    n = next_q[t];
    if (p < SLOTS) next_q[p] = n;
    else head_q = n;
    if (n < SLOTS) prev_q[n] = p;
    else tail_q = p;
    queued_q[t] = 1'b0;
    queued_count--;
  endfunction

  // Apply one request to the shadow queue and return its result word.
  function automatic rsp_t apply_request(req_t req);
    rsp_t r;
    int t;
    r = '0;
    t = int'(req.task_slot);
    case (req.action)
      ACT_ADD_BACK, ACT_PUSH_FRONT: begin
        if (queued_q[t]) r.op_error = 1'b1;
        else begin
          if (head_q == NIL) begin
            head_q = t;
            tail_q = t;
            prev_q[t] = NIL;
            next_q[t] = NIL;
          end else if (req.action == ACT_ADD_BACK) begin
            next_q[tail_q] = t;
            prev_q[t] = tail_q;
            next_q[t] = NIL;
            tail_q = t;
          end else begin
            next_q[t] = head_q;
            prev_q[head_q] = t;
            prev_q[t] = NIL;
            head_q = t;
          end
          queued_q[t] = 1'b1;
          queued_count++;
        end
      end
      ACT_TAKE_FRONT, ACT_PEEK_FRONT: begin
        if (head_q != NIL) begin
          r.out_task = head_q[5:0];
          r.out_valid = 1'b1;
          if (req.action == ACT_TAKE_FRONT) unlink_task(head_q);
        end
      end
      ACT_ERASE: begin
        if (!queued_q[t]) r.op_error = 1'b1;
        else unlink_task(t);
      end
      default: ;
    endcase
    r.queue_empty = (head_q == NIL);
    return r;
  endfunction

  // Drive one request word after a random gap; hold until accepted.
  task automatic send_request(logic [2:0] action, logic [5:0] slot);
    req_t req;
    rsp_t exp_word;
    int gap;
    req.action = action;
    req.task_slot = slot;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_word = apply_request(req);
    expected_words.insert(expected_words.size(), exp_word);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Receiver: wait a random number of cycles per word, then take it
  initial begin : receiver
    int wait_n;
    forever begin
      wait_n = $urandom_range(0, 11);
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(rst_ni && out_valid_o && out_ready_i)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      word_count++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %p", out_data_o);
        fail_count++;
      end else begin
        rsp_t e;
        e = expected_words[0];
        expected_words.delete(0);
        if (out_data_o.out_task !== e.out_task) begin
          $error("out_task expected %0d actual %0d", e.out_task, out_data_o.out_task);
          fail_count++;
        end
        if (out_data_o.out_valid !== e.out_valid) begin
          $error("out_valid expected %0b actual %0b", e.out_valid, out_data_o.out_valid);
          fail_count++;
        end
        if (out_data_o.queue_empty !== e.queue_empty) begin
          $error("queue_empty expected %0b actual %0b", e.queue_empty,
                 out_data_o.queue_empty);
          fail_count++;
        end
        if (out_data_o.op_error !== e.op_error) begin
          $error("op_error expected %0b actual %0b", e.op_error, out_data_o.op_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: stop when no word moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** doubly_linked_task_queue_core: FAILED **");
      $finish;
    end
  end

  // Edge cases: empty pops, double push, stray erase, extremes, bad actions.
  task automatic test_directed();
    send_request(ACT_TAKE_FRONT, 6'd0);
    send_request(ACT_PEEK_FRONT, 6'd63);
    send_request(ACT_ERASE, 6'd0);
    send_request(ACT_ADD_BACK, 6'd0);
    send_request(ACT_ADD_BACK, 6'd0);
    send_request(ACT_PUSH_FRONT, 6'd0);
    send_request(ACT_PUSH_FRONT, 6'd63);
    send_request(ACT_ADD_BACK, 6'd42);
    send_request(ACT_ADD_BACK, 6'd21);
    send_request(ACT_PEEK_FRONT, 6'd0);
    send_request(ACT_ERASE, 6'd42);
    send_request(ACT_ERASE, 6'd42);
    send_request(3'd5, 6'd7);
    send_request(3'd6, 6'd63);
    send_request(3'd7, 6'd0);
    send_request(ACT_ERASE, 6'd21);
    send_request(ACT_TAKE_FRONT, 6'd63);
    send_request(ACT_ERASE, 6'd0);
    send_request(ACT_TAKE_FRONT, 6'd0);
    send_request(ACT_PEEK_FRONT, 6'd0);
  endtask

  // Random traffic; erases are mostly aimed at queued slots so they hit the middle.
  task automatic test_random(int count);
    int sel;
    logic [5:0] slot;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      slot = 6'($urandom_range(0, 63));
      if (sel < 30) send_request(ACT_ADD_BACK, slot);
      else if (sel < 50) send_request(ACT_PUSH_FRONT, slot);
      else if (sel < 65) send_request(ACT_TAKE_FRONT, slot);
      else if (sel < 88) begin
        if (queued_count > 0 && $urandom_range(0, 3) != 0) begin
          while (!queued_q[slot]) slot = 6'($urandom_range(0, 63));
        end
        send_request(ACT_ERASE, slot);
      end else if (sel < 96) send_request(ACT_PEEK_FRONT, slot);
      else send_request(3'($urandom_range(5, 7)), slot);
      if (i == count / 2) wait_drained();
    end
  endtask

  // Fill the whole pool, push a queued slot again, then drain it by pops, one past empty.
  task automatic test_full_pool();
    for (int i = 0; i < SLOTS; i++) send_request(ACT_ADD_BACK, i[5:0]);
    send_request(ACT_PUSH_FRONT, 6'd17);
    for (int i = 0; i < SLOTS + 1; i++) send_request(ACT_TAKE_FRONT, 6'd0);
  endtask

  initial begin
    clear_queue();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_pool();
    test_random(1500);
    wait_drained();
    $display("Covered %0d result words: every action, empty and full pool,", word_count);
    $display("double pushes, stray erases, unknown actions and random stalls.");
    if (fail_count == 0) $display("** doubly_linked_task_queue_core: PASSED **");
    else $display("** doubly_linked_task_queue_core: FAILED **");
    $finish;
  end

endmodule
